// File: rtl/core/ferp_pkg.sv
// ----------------------------------------------------------------------------
// ferp_pkg
// Shared types and constants of the frame echo record and playback buffer.
// ----------------------------------------------------------------------------
package ferp_pkg;

	localparam int FRAME_BYTES_DEF    = 122;
	localparam int BUFFER_BYTES_DEF   = 16384;
	localparam int HEADROOM_BYTES_DEF = 1000;

	localparam int DATA_W  = 8;
	localparam int MS_W    = 10;
	localparam int DELAY_W = 16;

	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(2000);

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_EOT   = 2'd1,
		OP_TICK  = 2'd2,
		OP_READ  = 2'd3
	} ferp_op_t;

	// per-item result flags, data byte travels separately from the ram
	typedef struct packed {
		logic write_accepted;
		logic data_valid;
		logic frame_last;
		logic playback_ready;
	} ferp_res_t;

endpackage

// File: rtl/core/ferp_ram.sv
// ----------------------------------------------------------------------------
// ferp_ram
// Generic single-clock ram, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ferp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/ferp_ctrl.sv
// ----------------------------------------------------------------------------
// ferp_ctrl
// Fill, pointer, frame and timer bookkeeping; drives the frame store ram.
// ----------------------------------------------------------------------------
module ferp_ctrl #(
	parameter int FRAME_BYTES    = ferp_pkg::FRAME_BYTES_DEF,
	parameter int BUFFER_BYTES   = ferp_pkg::BUFFER_BYTES_DEF,
	parameter int HEADROOM_BYTES = ferp_pkg::HEADROOM_BYTES_DEF,
	localparam int ADDR_W = $clog2(BUFFER_BYTES),
	localparam int FILL_W = $clog2(BUFFER_BYTES + 1),
	localparam int OFF_W  = $clog2(FRAME_BYTES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [1:0]                   operation,
	input  logic [ferp_pkg::DATA_W-1:0]  data_in,
	input  logic [ferp_pkg::MS_W-1:0]    elapsed_ms,
	input  logic                         cfg_we,
	input  logic [ferp_pkg::DELAY_W-1:0] cfg_wdata,
	output logic                         ram_we,
	output logic [ADDR_W-1:0]            ram_waddr,
	output logic [ferp_pkg::DATA_W-1:0]  ram_wdata,
	output logic                         ram_re,
	output logic [ADDR_W-1:0]            ram_raddr,
	output ferp_pkg::ferp_res_t          res
);

	localparam logic [FILL_W-1:0] BUF_SIZE     = FILL_W'(BUFFER_BYTES);
	localparam logic [FILL_W-1:0] REFUSE_ABOVE = FILL_W'(BUFFER_BYTES - HEADROOM_BYTES);
	localparam logic [OFF_W:0]    FRAME_LEN    = (OFF_W + 1)'(FRAME_BYTES);

	logic [FILL_W-1:0]            fill_q, fill_d;
	logic [FILL_W-1:0]            rptr_q, rptr_d;
	logic [OFF_W-1:0]             woff_q, woff_d;
	logic [OFF_W-1:0]             roff_q, roff_d;
	logic                         refused_q, refused_d;
	logic                         running_q, running_d;
	logic [ferp_pkg::DELAY_W-1:0] elapsed_q, elapsed_d;
	logic [ferp_pkg::DELAY_W-1:0] delay_q;

	ferp_pkg::ferp_op_t           op;
	logic [OFF_W:0]               woff_inc;
	logic [OFF_W:0]               roff_inc;
	logic                         refuse_now;
	logic                         store_ok;
	logic                         rd_hit;
	logic [ferp_pkg::DELAY_W:0]   tick_sum;

	assign op       = ferp_pkg::ferp_op_t'(operation);
	assign woff_inc = {1'b0, woff_q} + (OFF_W + 1)'(1);
	assign roff_inc = {1'b0, roff_q} + (OFF_W + 1)'(1);
	assign tick_sum = {1'b0, elapsed_q} + (ferp_pkg::DELAY_W + 1)'(elapsed_ms);

	// room check only at the first byte of a frame
	assign refuse_now = (woff_q == '0) ? (fill_q > REFUSE_ABOVE) : refused_q;
	assign store_ok   = !refuse_now && (fill_q < BUF_SIZE);
	assign rd_hit     = (rptr_q < fill_q) && (rptr_q < BUF_SIZE);

	assign ram_we    = accept && (op == ferp_pkg::OP_WRITE) && store_ok;
	assign ram_waddr = fill_q[ADDR_W-1:0];
	assign ram_wdata = data_in;
	assign ram_re    = accept && (op == ferp_pkg::OP_READ) && (fill_q != '0) && rd_hit;
	assign ram_raddr = rptr_q[ADDR_W-1:0];

	always_comb begin
		fill_d    = fill_q;
		rptr_d    = rptr_q;
		woff_d    = woff_q;
		roff_d    = roff_q;
		refused_d = refused_q;
		running_d = running_q;
		elapsed_d = elapsed_q;
		res       = '0;
		case (op)
			ferp_pkg::OP_WRITE: begin
				refused_d = refuse_now;
				if (store_ok) begin
					fill_d             = fill_q + FILL_W'(1);
					res.write_accepted = 1'b1;
				end
				if (woff_inc >= FRAME_LEN) begin
					woff_d         = '0;
					res.frame_last = 1'b1;
				end else begin
					woff_d = woff_inc[OFF_W-1:0];
				end
			end
			ferp_pkg::OP_EOT: begin
				if (fill_q != '0) begin
					running_d = 1'b1;
					elapsed_d = '0;
				end
				rptr_d    = '0;
				roff_d    = '0;
				woff_d    = '0;
				refused_d = 1'b0;
			end
			ferp_pkg::OP_TICK: begin
				if (running_q) begin
					elapsed_d = tick_sum[ferp_pkg::DELAY_W] ? '1
					            : tick_sum[ferp_pkg::DELAY_W-1:0];
				end
			end
			ferp_pkg::OP_READ: begin
				if (fill_q != '0) begin
					if (rd_hit) begin
						rptr_d         = rptr_q + FILL_W'(1);
						res.data_valid = 1'b1;
					end
					if (roff_inc >= FRAME_LEN) begin
						roff_d         = '0;
						res.frame_last = 1'b1;
						// whole recording played back
						if (rptr_d >= fill_q) begin
							running_d = 1'b0;
							fill_d    = '0;
						end
					end else begin
						roff_d = roff_inc[OFF_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
		res.playback_ready = running_d && (elapsed_d >= delay_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			rptr_q    <= '0;
			woff_q    <= '0;
			roff_q    <= '0;
			refused_q <= 1'b0;
			running_q <= 1'b0;
			elapsed_q <= '0;
			delay_q   <= ferp_pkg::DELAY_RESET;
		end else begin
			if (accept) begin
				fill_q    <= fill_d;
				rptr_q    <= rptr_d;
				woff_q    <= woff_d;
				roff_q    <= roff_d;
				refused_q <= refused_d;
				running_q <= running_d;
				elapsed_q <= elapsed_d;
			end
			if (cfg_we) begin
				delay_q <= cfg_wdata;
			end
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= BUF_SIZE)
		else $error("fill level beyond buffer size");

	a_woff_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, woff_q} < FRAME_LEN)
		else $error("write frame offset out of range");

	a_roff_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, roff_q} < FRAME_LEN)
		else $error("read frame offset out of range");

	a_timer_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (fill_q != '0))
		else $error("timer running with empty buffer");

endmodule

// File: rtl/core/frame_echo_record_playback.sv
// ----------------------------------------------------------------------------
// frame_echo_record_playback
// Record-and-replay echo buffer for fixed-size frames, one byte per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one item: operation with data_in
// for a write byte and elapsed_ms for a time tick. Every item gives exactly
// one result item on the output channel (out_valid/out_ready).
// A result passes the frame store read and read stage (res_s1), then the
// output register. Throughput: one item per cycle while the receiver takes
// results; all counters are updated in the accept cycle and the store takes
// one write or one read per item. The playback delay delay_q is loaded via
// cfg_we/cfg_wdata; the user is to load it only while the block is idle and
// the block does not enforce it. Reset clears fill level, pointers, frame
// offsets and the timer and sets the delay to 2000 ms; store contents stay,
// since only entries below the fill level are ever read. No clearing pass is
// needed. When the receiver stalls, the result waits in the output register,
// one more item moves into the read stage, and then in_ready drops until the
// output register is taken.
// ----------------------------------------------------------------------------
module frame_echo_record_playback #(
	parameter int FRAME_BYTES    = ferp_pkg::FRAME_BYTES_DEF,
	parameter int BUFFER_BYTES   = ferp_pkg::BUFFER_BYTES_DEF,
	parameter int HEADROOM_BYTES = ferp_pkg::HEADROOM_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [ferp_pkg::DATA_W-1:0]  data_in,
	input  logic [ferp_pkg::MS_W-1:0]    elapsed_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         write_accepted,
	output logic [ferp_pkg::DATA_W-1:0]  data_out,
	output logic                         data_valid,
	output logic                         frame_last,
	output logic                         playback_ready,
	input  logic                         cfg_we,
	input  logic [ferp_pkg::DELAY_W-1:0] cfg_wdata
);

	localparam int ADDR_W = $clog2(BUFFER_BYTES);

	logic                        accept;
	logic                        ram_we;
	logic [ADDR_W-1:0]           ram_waddr;
	logic [ferp_pkg::DATA_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [ADDR_W-1:0]           ram_raddr;
	logic [ferp_pkg::DATA_W-1:0] ram_rdata;
	ferp_pkg::ferp_res_t         res;

	logic                        valid_s1;
	ferp_pkg::ferp_res_t         res_s1;
	logic                        out_valid_q;
	ferp_pkg::ferp_res_t         res_q;
	logic [ferp_pkg::DATA_W-1:0] data_q;
	logic                        adv_s1;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	ferp_ctrl #(
		.FRAME_BYTES    (FRAME_BYTES),
		.BUFFER_BYTES   (BUFFER_BYTES),
		.HEADROOM_BYTES (HEADROOM_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (operation),
		.data_in    (data_in),
		.elapsed_ms (elapsed_ms),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.res        (res)
	);

	ferp_ram #(
		.WIDTH (ferp_pkg::DATA_W),
		.DEPTH (BUFFER_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= accept;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
		if (adv_s1) begin
			res_q  <= res_s1;
			// ram data holds while the read stage is stalled
			data_q <= res_s1.data_valid ? ram_rdata : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign write_accepted = res_q.write_accepted;
	assign data_out       = data_q;
	assign data_valid     = res_q.data_valid;
	assign frame_last     = res_q.frame_last;
	assign playback_ready = res_q.playback_ready;

	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.data_valid) |-> (data_q == '0))
		else $error("data_out not zero without a stored byte");

	a_write_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.write_accepted && res_q.data_valid))
		else $error("result flags a write and a read at once");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |=> out_valid_q)
		else $error("read stage did not move into free output register");

endmodule

// File: tb/frame_echo_record_playback_tb.sv
// ----------------------------------------------------------------------------
// frame_echo_record_playback_tb
// Self-checking bench for the frame echo record and playback buffer. Bytes
// are recorded, the delay timer is run, and the frames are played back; a
// model of the buffer predicts every result item, and each one the block
// returns is checked against the oldest prediction. The sender works in
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module frame_echo_record_playback_tb;

	localparam int DATA_W    = ferp_pkg::DATA_W;
	localparam int MS_W      = ferp_pkg::MS_W;
	localparam int DELAY_W   = ferp_pkg::DELAY_W;
	localparam int FRAME     = ferp_pkg::FRAME_BYTES_DEF;
	localparam int STORE     = ferp_pkg::BUFFER_BYTES_DEF;
	localparam int HEADROOM  = ferp_pkg::HEADROOM_BYTES_DEF;
	localparam int MS_MAX    = 1000;
	localparam int ELAPSED_SAT = 65535;
	localparam int IDLE_LIMIT  = 5000;
	localparam int TOTAL_ITEMS = 1750;

	typedef struct packed {
		logic                accepted;
		logic [DATA_W-1:0]   byte_out;
		logic                byte_valid;
		logic                last;
		logic                ready;
	} echo_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [1:0]          operation = ferp_pkg::OP_READ;
	logic [DATA_W-1:0]   data_in = '0;
	logic [MS_W-1:0]     elapsed_ms = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                write_accepted;
	logic [DATA_W-1:0]   data_out;
	logic                data_valid;
	logic                frame_last;
	logic                playback_ready;
	logic                cfg_we = 1'b0;
	logic [DELAY_W-1:0]  cfg_wdata = '0;

	frame_echo_record_playback dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.data_in        (data_in),
		.elapsed_ms     (elapsed_ms),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.write_accepted (write_accepted),
		.data_out       (data_out),
		.data_valid     (data_valid),
		.frame_last     (frame_last),
		.playback_ready (playback_ready),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	always #4 clk = ~clk;

	// model of the buffer, advanced once per accepted item
	logic [DATA_W-1:0]  rec_store [0:STORE-1];
	int                 rec_fill;
	int                 play_ptr;
	int                 wr_offset;
	int                 rd_offset;
	bit                 wr_refused;
	bit                 delay_running;
	int                 delay_elapsed;
	logic [DELAY_W-1:0] delay_setting;

	echo_result_t echo_expected [$];
	echo_result_t got_result;
	echo_result_t want_result;
	int           mismatch_count;
	int           result_count;
	int           item_count;
	int           tx_burst_left;
	int           rx_hold_cycles;
	int           rx_run_left;
	int           rx_mode;
	int           idle_cycles;

	function automatic bit echo_ready_now();
		return delay_running && (delay_elapsed >= int'(delay_setting));
	endfunction

	function automatic echo_result_t echo_predict(ferp_pkg::ferp_op_t op,
			logic [DATA_W-1:0] din, logic [MS_W-1:0] ms);
		echo_result_t r;
		r = '0;
		case (op)
			ferp_pkg::OP_WRITE: begin
				if (wr_offset == 0)
					wr_refused = (STORE - rec_fill) < HEADROOM;
				if (!wr_refused && rec_fill < STORE) begin
					rec_store[rec_fill] = din;
					rec_fill++;
					r.accepted = 1'b1;
				end
				wr_offset++;
				if (wr_offset >= FRAME) begin
					wr_offset = 0;
					r.last = 1'b1;
				end
			end
			ferp_pkg::OP_EOT: begin
				if (rec_fill > 0) begin
					delay_running = 1'b1;
					delay_elapsed = 0;
				end
				play_ptr = 0;
				rd_offset = 0;
				wr_offset = 0;
				wr_refused = 1'b0;
			end
			ferp_pkg::OP_TICK: begin
				if (delay_running) begin
					delay_elapsed += int'(ms);
					if (delay_elapsed > ELAPSED_SAT)
						delay_elapsed = ELAPSED_SAT;
				end
			end
			default: begin
				if (rec_fill > 0) begin
					if (play_ptr < rec_fill && play_ptr < STORE) begin
						r.byte_out = rec_store[play_ptr];
						r.byte_valid = 1'b1;
						play_ptr++;
					end
					rd_offset++;
					if (rd_offset >= FRAME) begin
						rd_offset = 0;
						r.last = 1'b1;
						// the frame that reaches the fill level empties the buffer
						if (play_ptr >= rec_fill) begin
							delay_running = 1'b0;
							rec_fill = 0;
						end
					end
				end
			end
		endcase
		r.ready = echo_ready_now();
		return r;
	endfunction

	task automatic send_item(input ferp_pkg::ferp_op_t op, input logic [DATA_W-1:0] din,
			input logic [MS_W-1:0] ms);
		int gap;
		if (tx_burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			tx_burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 48);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		tx_burst_left--;
		in_valid   <= 1'b1;
		operation  <= op;
		data_in    <= din;
		elapsed_ms <= ms;
		do @(posedge clk); while (!in_ready);
		echo_expected.push_back(echo_predict(op, din, ms));
		item_count++;
	endtask

	// sender stops and waits for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		while (echo_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_playback_delay(input logic [DELAY_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		delay_setting = value;
	endtask

	task automatic record_bytes(input int count);
		for (int k = 0; k < count; k++)
			send_item(ferp_pkg::OP_WRITE, DATA_W'($urandom_range(0, 255)),
				MS_W'($urandom_range(0, MS_MAX)));
	endtask

	task automatic tick_until_ready();
		while (delay_running && !echo_ready_now())
			send_item(ferp_pkg::OP_TICK, DATA_W'($urandom_range(0, 255)),
				MS_W'($urandom_range(0, MS_MAX)));
	endtask

	task automatic play_out_all();
		while (rec_fill != 0)
			send_item(ferp_pkg::OP_READ, DATA_W'($urandom_range(0, 255)),
				MS_W'($urandom_range(0, MS_MAX)));
	endtask

	task automatic send_noise();
		send_item(ferp_pkg::ferp_op_t'($urandom_range(0, 3)), DATA_W'($urandom_range(0, 255)),
			MS_W'($urandom_range(0, MS_MAX)));
	endtask

	// empty buffer, stopped timer, the delay threshold at its reset value
	task automatic test_idle_ops_and_reset_delay();
		send_item(ferp_pkg::OP_READ, 8'h3C, 10'd0);
		send_item(ferp_pkg::OP_TICK, 8'h00, 10'd1000);
		send_item(ferp_pkg::OP_EOT, 8'hFF, 10'd512);
		send_item(ferp_pkg::OP_WRITE, 8'h00, 10'd0);
		send_item(ferp_pkg::OP_WRITE, 8'hFF, 10'd1000);
		send_item(ferp_pkg::OP_WRITE, 8'h5A, 10'd0);
		send_item(ferp_pkg::OP_EOT, 8'h00, 10'd0);
		send_item(ferp_pkg::OP_TICK, 8'h00, 10'd0);
		send_item(ferp_pkg::OP_TICK, 8'h00, 10'd1000);
		send_item(ferp_pkg::OP_TICK, 8'hFF, 10'd999);
		send_item(ferp_pkg::OP_TICK, 8'h00, 10'd1);
		for (int k = 0; k < 5; k++)
			send_item(ferp_pkg::OP_READ, 8'h00, 10'd0);
		send_item(ferp_pkg::OP_EOT, 8'h00, 10'd0);
		send_item(ferp_pkg::OP_READ, 8'hAA, 10'd0);
	endtask

	// a whole frame then a short one, read back past the fill level
	task automatic test_full_and_partial_frames();
		record_bytes(FRAME + 5);
		send_item(ferp_pkg::OP_EOT, 8'h00, 10'd0);
		tick_until_ready();
		play_out_all();
		send_item(ferp_pkg::OP_READ, 8'h00, 10'd0);
	endtask

	task automatic test_delay_extremes();
		set_playback_delay(16'd0);
		record_bytes(10);
		send_item(ferp_pkg::OP_EOT, 8'h00, 10'd0);
		play_out_all();
		set_playback_delay(16'hFFFF);
		record_bytes(FRAME);
		send_item(ferp_pkg::OP_EOT, 8'h00, 10'd0);
		tick_until_ready();
		// elapsed is pinned at its ceiling now
		send_item(ferp_pkg::OP_TICK, 8'h00, 10'd1000);
		send_item(ferp_pkg::OP_TICK, 8'h00, 10'd1000);
		play_out_all();
		set_playback_delay(16'd1);
		record_bytes(3);
		send_item(ferp_pkg::OP_EOT, 8'h00, 10'd0);
		send_item(ferp_pkg::OP_TICK, 8'h00, 10'd0);
		send_item(ferp_pkg::OP_TICK, 8'h00, 10'd1);
		play_out_all();
	endtask

	task automatic test_output_backpressure();
		drain_results();
		rx_hold_cycles = 400;
		record_bytes(40);
		send_item(ferp_pkg::OP_EOT, 8'h00, 10'd0);
		drain_results();
		tick_until_ready();
		play_out_all();
		drain_results();
	endtask

	task automatic test_random_sessions();
		int writes;
		int reads;
		int session;
		session = 0;
		while (item_count < TOTAL_ITEMS) begin
			session++;
			if (session % 4 == 0) begin
				case ($urandom_range(0, 3))
					0: set_playback_delay(16'd0);
					1: set_playback_delay(16'hFFFF);
					2: set_playback_delay(16'd2000);
					default: set_playback_delay(DELAY_W'($urandom_range(1, 3000)));
				endcase
			end
			if ($urandom_range(0, 2) == 0)
				writes = $urandom_range(1, 2) * FRAME;
			else
				writes = $urandom_range(0, 2) * FRAME + $urandom_range(0, FRAME - 1);
			for (int k = 0; k < writes; k++) begin
				if ($urandom_range(0, 11) == 0)
					send_noise();
				record_bytes(1);
			end
			// a missing end of transmission now and then
			if ($urandom_range(0, 7) != 0)
				send_item(ferp_pkg::OP_EOT, DATA_W'($urandom_range(0, 255)),
					MS_W'($urandom_range(0, MS_MAX)));
			if ($urandom_range(0, 3) != 0)
				tick_until_ready();
			else
				repeat ($urandom_range(0, 4)) send_item(ferp_pkg::OP_TICK, 8'h00,
					MS_W'($urandom_range(0, MS_MAX)));
			if ($urandom_range(0, 2) == 0) begin
				// partial playback, then rewind
				reads = $urandom_range(1, FRAME + 20);
				for (int k = 0; k < reads; k++) begin
					if ($urandom_range(0, 15) == 0)
						send_noise();
					send_item(ferp_pkg::OP_READ, DATA_W'($urandom_range(0, 255)),
						MS_W'($urandom_range(0, MS_MAX)));
				end
				send_item(ferp_pkg::OP_EOT, 8'h00, 10'd0);
			end
			play_out_all();
			repeat ($urandom_range(0, 2)) send_noise();
		end
	endtask

	// receiver: long hold on request, otherwise stretches of differing stall patterns
	always @(posedge clk) begin
		if (rx_hold_cycles > 0) begin
			out_ready <= 1'b0;
			rx_hold_cycles--;
		end else begin
			if (rx_run_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_run_left = $urandom_range(8, 120);
			end
			rx_run_left--;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 9) < 7);
				2: out_ready <= ~out_ready;
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			got_result = {write_accepted, data_out, data_valid, frame_last, playback_ready};
			if (echo_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result %0d arrived with nothing expected: ",
						"acc=%0b data=%02h valid=%0b last=%0b ready=%0b",
						result_count, got_result.accepted, got_result.byte_out,
						got_result.byte_valid, got_result.last, got_result.ready);
			end else begin
				want_result = echo_expected.pop_front();
				if (got_result !== want_result) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d mismatch: ",
							"expected acc=%0b data=%02h valid=%0b last=%0b ready=%0b, ",
							"got acc=%0b data=%02h valid=%0b last=%0b ready=%0b",
							result_count, want_result.accepted, want_result.byte_out,
							want_result.byte_valid, want_result.last, want_result.ready,
							got_result.accepted, got_result.byte_out, got_result.byte_valid,
							got_result.last, got_result.ready);
				end
			end
		end
	end

	// no item moving on either channel for too long means the block hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("frame_echo_record_playback verification failed");
				$finish;
			end
		end
	end

	initial begin
		rec_fill = 0;
		play_ptr = 0;
		wr_offset = 0;
		rd_offset = 0;
		wr_refused = 1'b0;
		delay_running = 1'b0;
		delay_elapsed = 0;
		delay_setting = ferp_pkg::DELAY_RESET;
		mismatch_count = 0;
		result_count = 0;
		item_count = 0;
		tx_burst_left = 0;
		rx_hold_cycles = 0;
		rx_run_left = 0;
		rx_mode = 0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ops_and_reset_delay();
		test_full_and_partial_frames();
		test_delay_extremes();
		test_output_backpressure();
		test_random_sessions();
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && echo_expected.size() == 0)
			$display("frame_echo_record_playback verification clean");
		else
			$display("frame_echo_record_playback verification failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/ferp_pkg.sv
rtl/core/ferp_ram.sv
rtl/core/ferp_ctrl.sv
rtl/core/frame_echo_record_playback.sv
tb/frame_echo_record_playback_tb.sv
